// ----- src/ssu_pkg.sv -----
package ssu_pkg;

	localparam int FifoDepth = 4;
	localparam int PtrW      = $clog2(FifoDepth);
	localparam int CntW      = $clog2(FifoDepth + 1);
	localparam int MaxBytes  = 4;
	localparam int IdxW      = $clog2(MaxBytes);
	localparam int NumW      = $clog2(MaxBytes + 1);

	// decoded bytes caused by one input word
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [NumW-1:0]          count;
		logic                     last;
	} group_t;

endpackage

// ----- src/ssu_front.sv -----
module ssu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          byte_in,
	input  logic                last_in,
	input  logic                q_full,
	output logic                q_push,
	output ssu_pkg::group_t     q_wdata
);

	localparam logic [7:0] ChQuote  = 8'h27;
	localparam logic [7:0] ChBsl    = 8'h5C;
	localparam logic [7:0] ChDquote = 8'h22;
	localparam logic [7:0] ChLx     = 8'h78;
	localparam logic [7:0] ChUx     = 8'h58;
	localparam logic [7:0] Ch0      = 8'h30;
	localparam logic [7:0] Ch7      = 8'h37;
	localparam logic [7:0] Ch9      = 8'h39;
	localparam logic [7:0] ChLa     = 8'h61;
	localparam logic [7:0] ChLf     = 8'h66;
	localparam logic [7:0] ChUa     = 8'h41;
	localparam logic [7:0] ChUf     = 8'h46;
	localparam logic [7:0] ChLn     = 8'h6E;
	localparam logic [7:0] ChLt     = 8'h74;
	localparam logic [7:0] ChLr     = 8'h72;
	localparam logic [7:0] ChNl     = 8'h0A;
	localparam logic [7:0] ChTab    = 8'h09;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [1:0] OctMax   = 2'd3;

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_QUOTE = 3'd1,
		M_BSL   = 3'd2,
		M_HEX0  = 3'd3,
		M_HEX1  = 3'd4,
		M_OCT   = 3'd5
	} mode_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= Ch0 && c <= Ch9) || (c >= ChLa && c <= ChLf) ||
			(c >= ChUa && c <= ChUf);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		if (c <= Ch9) begin
			t = c - Ch0;
		end else if (c >= ChLa) begin
			t = c - ChLa + 8'd10;
		end else begin
			t = c - ChUa + 8'd10;
		end
		return t[3:0];
	endfunction

	mode_t      mode_q, mode_d;
	logic [7:0] acc_q, acc_d;
	logic [1:0] digs_q, digs_d;
	logic       upper_q, upper_d;
	logic [7:0] fh_q, fh_d;

	logic [ssu_pkg::MaxBytes-1:0][7:0] em;
	logic [ssu_pkg::NumW-1:0]          n;
	logic                              fresh;
	logic                              is_oct;
	logic [7:0]                        xch;
	logic                              take;

	assign is_oct = (byte_in >= Ch0) && (byte_in <= Ch7);
	assign xch    = upper_q ? ChUx : ChLx;

	always_comb begin
		em     = '0;
		n      = '0;
		fresh  = 1'b0;
		mode_d = mode_q;
		acc_d  = acc_q;
		digs_d = digs_q;
		upper_d = upper_q;
		fh_d   = fh_q;

		unique case (mode_q)
			M_QUOTE: begin
				em[0] = ChQuote;
				n = ssu_pkg::NumW'(1);
				if (byte_in == ChQuote) begin
					mode_d = M_IDLE;
				end else begin
					fresh = 1'b1;
				end
			end
			M_BSL: begin
				mode_d = M_IDLE;
				priority if (byte_in == ChLx || byte_in == ChUx) begin
					upper_d = (byte_in == ChUx);
					mode_d = M_HEX0;
				end else if (is_oct) begin
					acc_d  = {5'd0, byte_in[2:0]};
					digs_d = 2'd1;
					mode_d = M_OCT;
				end else if (byte_in == ChLn) begin
					em[0] = ChNl;
					n = ssu_pkg::NumW'(1);
				end else if (byte_in == ChLt) begin
					em[0] = ChTab;
					n = ssu_pkg::NumW'(1);
				end else if (byte_in == ChLr) begin
					em[0] = ChCr;
					n = ssu_pkg::NumW'(1);
				end else if (byte_in == ChBsl || byte_in == ChQuote || byte_in == ChDquote) begin
					em[0] = byte_in;
					n = ssu_pkg::NumW'(1);
				end else begin
					em[0] = ChBsl;
					em[1] = byte_in;
					n = ssu_pkg::NumW'(2);
				end
			end
			M_HEX0: begin
				if (is_hex(byte_in)) begin
					fh_d = byte_in;
					mode_d = M_HEX1;
				end else begin
					em[0] = ChBsl;
					em[1] = xch;
					n = ssu_pkg::NumW'(2);
					fresh = 1'b1;
				end
			end
			M_HEX1: begin
				if (is_hex(byte_in)) begin
					em[0] = {hex_val(fh_q), hex_val(byte_in)};
					n = ssu_pkg::NumW'(1);
					mode_d = M_IDLE;
				end else begin
					em[0] = ChBsl;
					em[1] = xch;
					em[2] = fh_q;
					n = ssu_pkg::NumW'(3);
					fresh = 1'b1;
				end
			end
			M_OCT: begin
				if (is_oct && digs_q < OctMax) begin
					acc_d  = {acc_q[4:0], byte_in[2:0]};
					digs_d = digs_q + 2'd1;
					if (digs_q + 2'd1 == OctMax) begin
						em[0] = acc_d;
						n = ssu_pkg::NumW'(1);
						mode_d = M_IDLE;
					end
				end else begin
					em[0] = acc_q;
					n = ssu_pkg::NumW'(1);
					fresh = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		// byte not consumed by the escape starts over from idle
		if (fresh) begin
			if (byte_in == ChQuote) begin
				mode_d = M_QUOTE;
			end else if (byte_in == ChBsl) begin
				mode_d = M_BSL;
			end else begin
				mode_d = M_IDLE;
				em[n[ssu_pkg::IdxW-1:0]] = byte_in;
				n = n + ssu_pkg::NumW'(1);
			end
		end

		// end of string: flush what is still open
		if (last_in) begin
			unique case (mode_d)
				M_QUOTE: begin
					em[n[ssu_pkg::IdxW-1:0]] = ChQuote;
					n = n + ssu_pkg::NumW'(1);
				end
				M_BSL: begin
					em[n[ssu_pkg::IdxW-1:0]] = ChBsl;
					n = n + ssu_pkg::NumW'(1);
				end
				M_HEX0: begin
					em[n[ssu_pkg::IdxW-1:0]] = ChBsl;
					em[n[ssu_pkg::IdxW-1:0] + 2'd1] = upper_d ? ChUx : ChLx;
					n = n + ssu_pkg::NumW'(2);
				end
				M_HEX1: begin
					em[n[ssu_pkg::IdxW-1:0]] = ChBsl;
					em[n[ssu_pkg::IdxW-1:0] + 2'd1] = upper_d ? ChUx : ChLx;
					em[n[ssu_pkg::IdxW-1:0] + 2'd2] = fh_d;
					n = n + ssu_pkg::NumW'(3);
				end
				M_OCT: begin
					em[n[ssu_pkg::IdxW-1:0]] = acc_d;
					n = n + ssu_pkg::NumW'(1);
				end
				default: begin
				end
			endcase
			mode_d  = M_IDLE;
			acc_d   = '0;
			digs_d  = '0;
			upper_d = 1'b0;
			fh_d    = '0;
		end
	end

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign q_push   = take && (n != '0);
	assign q_wdata  = '{bytes: em, count: n, last: last_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			acc_q   <= '0;
			digs_q  <= '0;
			upper_q <= 1'b0;
			fh_q    <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			digs_q  <= digs_d;
			upper_q <= upper_d;
			fh_q    <= fh_d;
		end
	end

endmodule

// ----- src/ssu_fifo.sv -----
module ssu_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssu_pkg::group_t wdata,
	output logic            full,
	input  logic            pop,
	output ssu_pkg::group_t rdata,
	output logic            empty
);

	ssu_pkg::group_t                mem_q [ssu_pkg::FifoDepth];
	logic [ssu_pkg::PtrW-1:0]      wr_q, rd_q;
	logic [ssu_pkg::CntW-1:0]      cnt_q;

	assign full  = (cnt_q == ssu_pkg::CntW'(ssu_pkg::FifoDepth));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + ssu_pkg::PtrW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + ssu_pkg::PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + ssu_pkg::CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - ssu_pkg::CntW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ssu_pkg::CntW'(ssu_pkg::FifoDepth)) else $error("queue count out of range");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + ssu_pkg::CntW'(1))
		else $error("queue count did not advance");

endmodule

// ----- src/ssu_back.sv -----
module ssu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ssu_pkg::group_t head,
	input  logic            empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      byte_out,
	output logic            last_out
);

	logic                      out_valid_q;
	logic [7:0]                byte_out_q;
	logic                      last_out_q;
	logic [ssu_pkg::IdxW-1:0]  idx_q;
	logic                      load;
	logic                      at_end;

	assign load   = !empty && (!out_valid_q || out_ready);
	assign at_end = (ssu_pkg::NumW'(idx_q) + ssu_pkg::NumW'(1) == head.count);
	assign pop    = load && at_end;

	assign out_valid = out_valid_q;
	assign byte_out  = byte_out_q;
	assign last_out  = last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_out_q  <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				last_out_q  <= head.last && at_end;
				idx_q       <= at_end ? '0 : idx_q + ssu_pkg::IdxW'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_out_q <= head.bytes[idx_q];
		end
	end

	// a word leaving the queue was fully walked
	a_idx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0) else $error("byte index not cleared after pop");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ssu_pkg::NumW'(idx_q) < head.count) else $error("byte index past word");
	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(load && head.last && at_end) |-> pop) else $error("last byte without pop");

endmodule

// ----- src/sql_string_unescape.sv -----
// An accepted input word is written into the queue, and its first decoded byte is then loaded into the output register.
// Throughput: one input word per cycle while the 4-entry queue has room; the output
// drains one byte per cycle unless out_ready stalls it; a word decoding to n bytes pops with its last byte.
// Words that decode to nothing (open escapes) do not enter the queue.
// Reset (arst_n low, asynchronous): decoder state idle, queue empty, output not valid.
module sql_string_unescape (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic       last_out
);

	ssu_pkg::group_t wdata, rdata;
	logic            push, pop, full, empty;

	ssu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.byte_in  (byte_in),
		.last_in  (last_in),
		.q_full   (full),
		.q_push   (push),
		.q_wdata  (wdata)
	);

	ssu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.full   (full),
		.pop    (pop),
		.rdata  (rdata),
		.empty  (empty)
	);

	ssu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (rdata),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.byte_out  (byte_out),
		.last_out  (last_out)
	);

endmodule

// ----- tb/sql_string_unescape_tb.sv -----
`timescale 1ns / 1ps

module sql_string_unescape_tb;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} word_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_QUOTE, ST_ESC, ST_HEX_A, ST_HEX_B, ST_OCT
	} dec_state_t;

	localparam logic [7:0] CH_SQ  = "'";
	localparam logic [7:0] CH_DQ  = "\"";
	localparam logic [7:0] CH_BSL = "\\";
	localparam logic [7:0] CH_XL  = "x";
	localparam logic [7:0] CH_XU  = "X";
	localparam logic [7:0] CH_0   = "0";
	localparam logic [7:0] CH_7   = "7";
	localparam logic [7:0] CH_N   = "n";
	localparam logic [7:0] CH_T   = "t";
	localparam logic [7:0] CH_R   = "r";
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam int RandWords = 110;
	localparam int QuietTail = 30;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] byte_in = 8'h00;
	logic       last_in = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] byte_out;
	logic       last_out;

	sql_string_unescape dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.byte_in  (byte_in),
		.last_in  (last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_out (byte_out),
		.last_out (last_out)
	);

	// raw words waiting to be sent, decoded words waiting to come out
	word_t      raw_q[$];
	word_t      decoded_q[$];
	logic [7:0] text_q[$];

	// decoder shadow state
	dec_state_t st = ST_IDLE;
	logic [7:0] oct_val = 8'h00;
	logic [1:0] oct_cnt = 2'd0;
	logic       hex_upper = 1'b0;
	logic [7:0] hex_first = 8'h00;
	int         step_n;

	int    errors = 0;
	int    n_taken = 0;
	int    n_total = 0;
	int    in_gap = 0;
	int    out_gap = 0;
	logic  in_fire = 1'b0;
	word_t tx_w;
	word_t rx_w;
	string hex_chars = "0123456789abcdefABCDEF";

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic is_hex_digit(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_digit_val(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 10);
		return 4'(c - "A" + 10);
	endfunction

	function automatic logic is_oct_digit(input logic [7:0] c);
		return c >= CH_0 && c <= CH_7;
	endfunction

	task automatic put_byte(input logic [7:0] b);
		word_t w;
		w.data = b;
		w.last = 1'b0;
		decoded_q = {decoded_q, w};
		step_n++;
	endtask

	task automatic take_plain(input logic [7:0] b);
		if (b == CH_SQ) begin
			st = ST_QUOTE;
		end else if (b == CH_BSL) begin
			st = ST_ESC;
		end else begin
			st = ST_IDLE;
			put_byte(b);
		end
	endtask

	// expected decoded words for one raw word
	task automatic decode_word(input logic [7:0] b, input logic lst);
		logic [7:0] xc;
		step_n = 0;
		xc = hex_upper ? CH_XU : CH_XL;
		case (st)
			ST_QUOTE: begin
				put_byte(CH_SQ);
				if (b == CH_SQ)
					st = ST_IDLE;
				else
					take_plain(b);
			end
			ST_ESC: begin
				st = ST_IDLE;
				if (b == CH_XL || b == CH_XU) begin
					hex_upper = (b == CH_XU);
					st = ST_HEX_A;
				end else if (is_oct_digit(b)) begin
					oct_val = b - CH_0;
					oct_cnt = 2'd1;
					st = ST_OCT;
				end else if (b == CH_N) begin
					put_byte(CH_LF);
				end else if (b == CH_T) begin
					put_byte(CH_TAB);
				end else if (b == CH_R) begin
					put_byte(CH_CR);
				end else if (b == CH_BSL || b == CH_SQ || b == CH_DQ) begin
					put_byte(b);
				end else begin
					put_byte(CH_BSL);
					put_byte(b);
				end
			end
			ST_HEX_A: begin
				if (is_hex_digit(b)) begin
					hex_first = b;
					st = ST_HEX_B;
				end else begin
					put_byte(CH_BSL);
					put_byte(xc);
					take_plain(b);
				end
			end
			ST_HEX_B: begin
				if (is_hex_digit(b)) begin
					put_byte({hex_digit_val(hex_first), hex_digit_val(b)});
					st = ST_IDLE;
				end else begin
					put_byte(CH_BSL);
					put_byte(xc);
					put_byte(hex_first);
					take_plain(b);
				end
			end
			ST_OCT: begin
				if (is_oct_digit(b) && oct_cnt < 2'd3) begin
					oct_val = {oct_val[4:0], 3'(b - CH_0)};
					oct_cnt++;
					if (oct_cnt == 2'd3) begin
						put_byte(oct_val);
						st = ST_IDLE;
					end
				end else begin
					put_byte(oct_val);
					take_plain(b);
				end
			end
			default: take_plain(b);
		endcase
		if (lst) begin
			// flush whatever sequence is still open; the marker may be new this word
			xc = hex_upper ? CH_XU : CH_XL;
			case (st)
				ST_QUOTE: put_byte(CH_SQ);
				ST_ESC:   put_byte(CH_BSL);
				ST_HEX_A: begin
					put_byte(CH_BSL);
					put_byte(xc);
				end
				ST_HEX_B: begin
					put_byte(CH_BSL);
					put_byte(xc);
					put_byte(hex_first);
				end
				ST_OCT:   put_byte(oct_val);
				default: ;
			endcase
			st = ST_IDLE;
			oct_val = 8'h00;
			oct_cnt = 2'd0;
			hex_upper = 1'b0;
			hex_first = 8'h00;
			if (step_n > 0)
				decoded_q[decoded_q.size() - 1].last = 1'b1;
		end
	endtask

	task automatic add_ch(input logic [7:0] b);
		text_q = {text_q, b};
	endtask

	task automatic add_txt(input string txt);
		for (int i = 0; i < txt.len(); i++)
			add_ch(txt[i]);
	endtask

	task automatic end_string();
		word_t w;
		for (int i = 0; i < text_q.size(); i++) begin
			w.data = text_q[i];
			w.last = (i == text_q.size() - 1);
			raw_q = {raw_q, w};
		end
		text_q.delete();
	endtask

	task automatic add_token();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			add_ch(8'($urandom_range(0, 255)));
		end else if (r < 40) begin
			add_ch(CH_SQ);
			add_ch(CH_SQ);
		end else if (r < 45) begin
			add_ch(CH_SQ);
		end else if (r < 60) begin
			add_ch(CH_BSL);
			case ($urandom_range(0, 5))
				0: add_ch(CH_N);
				1: add_ch(CH_T);
				2: add_ch(CH_R);
				3: add_ch(CH_BSL);
				4: add_ch(CH_SQ);
				default: add_ch(CH_DQ);
			endcase
		end else if (r < 70) begin
			add_ch(CH_BSL);
			add_ch($urandom_range(0, 1) ? CH_XU : CH_XL);
			add_ch(hex_chars[$urandom_range(0, 21)]);
			add_ch(hex_chars[$urandom_range(0, 21)]);
		end else if (r < 80) begin
			add_ch(CH_BSL);
			repeat ($urandom_range(1, 3))
				add_ch(CH_0 + 8'($urandom_range(0, 7)));
		end else if (r < 88) begin
			add_ch(CH_BSL);
			add_ch(8'($urandom_range(0, 255)));
		end else if (r < 95) begin
			// hex escape cut short or spoiled
			add_ch(CH_BSL);
			add_ch($urandom_range(0, 1) ? CH_XU : CH_XL);
			if ($urandom_range(0, 1))
				add_ch(hex_chars[$urandom_range(0, 21)]);
			add_ch(8'($urandom_range(0, 255)));
		end else begin
			add_ch(CH_BSL);
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (raw_q.size() > QuietTail && $urandom_range(0, 5) == 0) begin
				in_gap = $urandom_range(0, 8);
				in_valid <= 1'b0;
			end else if (raw_q.size() > 0) begin
				tx_w = raw_q.pop_front();
				in_valid <= 1'b1;
				byte_in <= tx_w.data;
				last_in <= tx_w.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (raw_q.size() > QuietTail && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				decode_word(byte_in, last_in);
				n_taken++;
			end
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected word byte_out %h last_out %b",
						$time, byte_out, last_out);
					errors++;
				end else begin
					rx_w = decoded_q.pop_front();
					if (byte_out !== rx_w.data) begin
						$display("%0t: byte_out expected %h actual %h",
							$time, rx_w.data, byte_out);
						errors++;
					end
					if (last_out !== rx_w.last) begin
						$display("%0t: last_out expected %b actual %b",
							$time, rx_w.last, last_out);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int n_dir;
		// zero byte, doubled quote, lone quote, unknown escape, all-ones byte
		add_ch(8'h00);
		add_txt("'''q\\q");
		add_ch(8'hFF);
		end_string();
		// hex with X, hex spoiled after one digit, three octal digits,
		// short octal ended by a quote left pending at the end
		add_txt("\\X4F\\xag\\777\\12'");
		end_string();
		// simple escapes, then a lone backslash at the end
		add_txt("\\n\\\\\\\"\\");
		end_string();
		// hex spoiled at once, then hex left open at the end
		add_txt("\\xq\\x5");
		end_string();
		n_dir = raw_q.size();
		while (raw_q.size() < n_dir + RandWords) begin
			repeat ($urandom_range(1, 6))
				add_token();
			end_string();
		end
		n_total = raw_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_taken < n_total || decoded_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
